// ===== sv/ssel_pkg.sv =====
`default_nettype none

package ssel_pkg;

    // Default table and selection sizes.
    localparam int MAX_SERVERS_DEF = 16;
    localparam int MAX_SELECT_DEF  = 8;

    // Field widths fixed by the word formats.
    localparam int ID_W    = 16;
    localparam int DEPTH_W = 16;
    localparam int RAND_W  = 32;
    localparam int POS_W   = 3;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    // Action codes of an input word.
    localparam logic [1:0] ACT_WR_ID    = 2'd0;
    localparam logic [1:0] ACT_WR_DEPTH = 2'd1;
    localparam logic [1:0] ACT_SELECT   = 2'd2;

    // Scatter policy codes; the unused code behaves as random start.
    localparam logic [1:0] POLICY_LOCAL  = 2'd0;
    localparam logic [1:0] POLICY_P2C    = 2'd1;
    localparam logic [1:0] POLICY_RANDOM = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SERVER_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LOCAL_ID     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_POLICY       = 2'd2;

    // Input word.
    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         slot;
        logic [ID_W-1:0]    server_word;
        logic [DEPTH_W-1:0] depth_word;
        logic [3:0]         select_count;
        logic [RAND_W-1:0]  random_word;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [ID_W-1:0]  selected_server;
        logic [POS_W-1:0] position;
        logic             last;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic div_step;
        logic pass_init;
        logic scan_issue;
        logic rd_best;
        logic rd_seq;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_sel;
        logic local_pol;
        logic full;
        logic div_last;
        logic scan_last;
        logic sort;
        logic out_free;
        logic last;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/ssel_ctrl.sv =====
`default_nettype none

module ssel_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ssel_pkg::t_status i_status,
    output ssel_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_INIT = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_TAIL = 8'b0001_0000,
        S_PICK = 8'b0010_0000,
        S_RD   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_status.start_sel) begin
                    if (i_status.local_pol) begin
                        n_state = S_OUT;
                    end else if (i_status.full) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = i_status.sort ? S_INIT : S_RD;
                end
            end
            S_INIT: begin
                o_cmd.pass_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.rd_best = 1'b1;
                n_state = S_OUT;
            end
            S_RD: begin
                o_cmd.rd_seq = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else if (i_status.sort) begin
                        n_state = S_INIT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssel_dp.sv =====
`default_nettype none

module ssel_dp #(
    parameter int MAX_SERVERS = ssel_pkg::MAX_SERVERS_DEF,
    parameter int MAX_SELECT  = ssel_pkg::MAX_SELECT_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [ssel_pkg::CIDX_W-1:0]         i_cfg_idx,
    input  wire [ssel_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  ssel_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output ssel_pkg::t_out_word                o_out_word,
    input  ssel_pkg::t_cmd                     i_cmd,
    output ssel_pkg::t_status                  o_status
);

    localparam int NW  = $clog2(MAX_SERVERS + 1);
    localparam int SLW = $clog2(MAX_SERVERS);
    localparam int CW  = $clog2(MAX_SELECT + 1);
    localparam int BCW = $clog2(ssel_pkg::RAND_W);

    // Configuration registers.
    logic [4:0]                   r_cfg_count;
    logic [ssel_pkg::ID_W-1:0]    r_cfg_local;
    logic [1:0]                   r_cfg_policy;

    // Table memories and their registered read data.
    logic [ssel_pkg::ID_W-1:0]    r_srv_mem [MAX_SERVERS];
    logic [ssel_pkg::DEPTH_W-1:0] r_dep_mem [MAX_SERVERS];
    logic [ssel_pkg::ID_W-1:0]    r_srv_q;
    logic [ssel_pkg::DEPTH_W-1:0] r_dep_q;

    // Request state.
    logic [NW-1:0]                r_n;
    logic [CW-1:0]                r_take;
    logic [CW-1:0]                r_k;
    logic [NW-1:0]                r_cands;
    logic                         r_local;
    logic                         r_sort;
    logic [ssel_pkg::RAND_W-1:0]  r_rand;
    logic [NW-1:0]                r_rem;
    logic [BCW-1:0]               r_bitc;
    logic [SLW-1:0]               r_start;
    logic [SLW-1:0]               r_slot;

    // Minimum search state.
    logic [SLW-1:0]               r_i;
    logic                         r_pv;
    logic [SLW-1:0]               r_pi;
    logic [SLW-1:0]               r_pslot;
    logic                         r_have;
    logic [SLW-1:0]               r_best_i;
    logic [SLW-1:0]               r_best_slot;
    logic [ssel_pkg::DEPTH_W-1:0] r_best_dep;
    logic [MAX_SERVERS-1:0]       r_used;

    // Output register.
    logic                         r_out_valid;
    ssel_pkg::t_out_word          r_out;

    logic                         w_acc;
    logic                         w_wr_ok;
    logic [SLW-1:0]               w_wslot;
    logic [7:0]                   w_n8;
    logic [7:0]                   w_c8;
    logic [7:0]                   w_c2;
    logic [7:0]                   w_cands8;
    logic [7:0]                   w_take8;
    logic                         w_full;
    logic                         w_sort;
    logic [NW:0]                  w_div_sh;
    logic [NW:0]                  w_div_nx;
    logic [NW-1:0]                w_slot_inc;
    logic [SLW-1:0]               w_slot_nx;
    logic [SLW-1:0]               w_rd_addr;
    logic                         w_better;
    logic                         w_last;

    // Input handshake and table write decode.
    assign o_in_ready = i_cmd.idle;
    assign w_acc      = i_in_valid & i_cmd.idle;
    assign w_wr_ok    = ({4'b0, i_in_word.slot} < 8'(MAX_SERVERS));
    assign w_wslot    = SLW'(i_in_word.slot);

    // Clamp server count and select count, size the candidate window.
    always_comb begin
        if (r_cfg_count == 5'd0) begin
            w_n8 = 8'd1;
        end else if ({3'b0, r_cfg_count} > 8'(MAX_SERVERS)) begin
            w_n8 = 8'(MAX_SERVERS);
        end else begin
            w_n8 = {3'b0, r_cfg_count};
        end
        if ({4'b0, i_in_word.select_count} > 8'(MAX_SELECT)) begin
            w_c8 = 8'(MAX_SELECT);
        end else begin
            w_c8 = {4'b0, i_in_word.select_count};
        end
        w_c2     = {w_c8[6:0], 1'b0};
        w_cands8 = (w_c2 > w_n8) ? w_n8 : w_c2;
        w_take8  = (w_c8 < w_cands8) ? w_c8 : w_cands8;
    end

    assign w_full = (w_c8 == w_n8);
    assign w_sort = (r_cfg_policy == ssel_pkg::POLICY_P2C) && !w_full;

    // One restoring division step per cycle, most significant bit first.
    assign w_div_sh = {r_rem, r_rand[ssel_pkg::RAND_W-1]};
    assign w_div_nx = (w_div_sh >= {1'b0, r_n}) ? (w_div_sh - {1'b0, r_n}) : w_div_sh;

    // Next slot, wrapping at the server count.
    assign w_slot_inc = NW'(r_slot) + NW'(1);
    assign w_slot_nx  = (w_slot_inc == r_n) ? '0 : w_slot_inc[SLW-1:0];

    // A candidate wins only on a strictly lower depth, so ties keep the earlier one.
    assign w_better = r_pv && !r_used[r_pi] && (!r_have || (r_dep_q < r_best_dep));

    assign w_rd_addr = i_cmd.rd_best ? r_best_slot : r_slot;
    assign w_last    = ((r_k + CW'(1)) == r_take);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= 5'd1;
            r_cfg_local  <= '0;
            r_cfg_policy <= ssel_pkg::POLICY_RANDOM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssel_pkg::CFG_SERVER_COUNT: r_cfg_count  <= i_cfg_wdata[4:0];
                ssel_pkg::CFG_LOCAL_ID:     r_cfg_local  <= i_cfg_wdata[15:0];
                ssel_pkg::CFG_POLICY:       r_cfg_policy <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // Table memories: one write and one registered read per table.
    // The id read is held while the output register waits for the receiver.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_wr_ok && (i_in_word.action == ssel_pkg::ACT_WR_ID)) begin
            r_srv_mem[w_wslot] <= i_in_word.server_word;
        end
        if (w_acc && w_wr_ok && (i_in_word.action == ssel_pkg::ACT_WR_DEPTH)) begin
            r_dep_mem[w_wslot] <= i_in_word.depth_word;
        end
        if (i_cmd.rd_best || i_cmd.rd_seq) begin
            r_srv_q <= r_srv_mem[w_rd_addr];
        end
        r_dep_q <= r_dep_mem[r_slot];
    end

    // Request setup, modulo, slot walk and minimum search.
    always_ff @(posedge i_clk) begin
        if (o_status.start_sel) begin
            r_n     <= w_n8[NW-1:0];
            r_cands <= w_cands8[NW-1:0];
            r_local <= (r_cfg_policy == ssel_pkg::POLICY_LOCAL);
            r_sort  <= w_sort;
            if (r_cfg_policy == ssel_pkg::POLICY_LOCAL) begin
                r_take <= CW'(1);
            end else if (w_sort) begin
                r_take <= w_take8[CW-1:0];
            end else begin
                r_take <= w_c8[CW-1:0];
            end
            r_k     <= '0;
            r_rand  <= i_in_word.random_word;
            r_rem   <= '0;
            r_bitc  <= BCW'(ssel_pkg::RAND_W - 1);
            r_start <= '0;
            r_slot  <= '0;
            r_used  <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_div_nx[NW-1:0];
            r_rand <= {r_rand[ssel_pkg::RAND_W-2:0], 1'b0};
            r_bitc <= r_bitc - BCW'(1);
            if (r_bitc == '0) begin
                r_start <= w_div_nx[SLW-1:0];
                r_slot  <= w_div_nx[SLW-1:0];
            end
        end
        if (i_cmd.pass_init) begin
            r_i    <= '0;
            r_slot <= r_start;
            r_have <= 1'b0;
        end
        if (i_cmd.scan_issue) begin
            r_pi    <= r_i;
            r_pslot <= r_slot;
            r_i     <= r_i + SLW'(1);
            r_slot  <= w_slot_nx;
        end
        if (i_cmd.rd_seq) begin
            r_slot <= w_slot_nx;
        end
        if (w_better) begin
            r_have      <= 1'b1;
            r_best_dep  <= r_dep_q;
            r_best_i    <= r_pi;
            r_best_slot <= r_pslot;
        end
        if (i_cmd.rd_best) begin
            r_used[r_best_i] <= 1'b1;
        end
        if (i_cmd.emit) begin
            r_k <= r_k + CW'(1);
        end
    end

    // Candidate read in flight; cleared at reset so no stale compare occurs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_issue;
        end
    end

    // Output register: holds one word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.selected_server <= r_local ? r_cfg_local : r_srv_q;
            r_out.position        <= ssel_pkg::POS_W'(r_k);
            r_out.last            <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Status to the controller.
    always_comb begin
        o_status           = '0;
        o_status.start_sel = w_acc && (i_in_word.action == ssel_pkg::ACT_SELECT)
                             && (i_in_word.select_count != 4'd0);
        o_status.local_pol = (r_cfg_policy == ssel_pkg::POLICY_LOCAL);
        o_status.full      = w_full;
        o_status.div_last  = (r_bitc == '0);
        o_status.scan_last = ((NW'(r_i) + NW'(1)) == r_cands);
        o_status.sort      = r_sort;
        o_status.out_free  = !r_out_valid || i_out_ready;
        o_status.last      = w_last;
    end

    // A word is loaded only when the output register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    // The remainder stays below the server count after every step.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_n))
        else $error("division remainder out of range");

    // The scan never runs past the candidate window.
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_issue |-> (NW'(r_i) < r_cands))
        else $error("candidate scan beyond window");

    // A pick always has a fresh winner that was not chosen before.
    a_pick_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_best |-> (r_have && !r_used[r_best_i]))
        else $error("pick without a valid unused candidate");

    // Never more words than the selection size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_k < r_take))
        else $error("more words emitted than selected");

endmodule

`default_nettype wire

// ===== sv/storage_server_selector_unit.sv =====
// Storage server selector: a load balancer with local, random-start and power-of-two-choices policies.
// Input channel (i_in_valid / o_in_ready / i_in_word): a word either writes a
// server id or a queue depth into slot i_in_word.slot (no result),
// or asks for select_count servers. Output channel (o_out_valid / i_out_ready /
// o_out_word) returns one chosen id per word, with its position and a last flag.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_wdata) writes server count, local
// id and policy; write it only while the block is idle.
// One request is in work at a time; the next word is taken once the final
// result has been loaded into the output register.
// Flow: local policy loads the output register directly; a full-table request
// reads the ids in sequence. Random start first takes the modulo (one quotient
// bit per cycle) and then reads ids in sequence. Power-of-two takes the same
// modulo and then picks each id at minimum depth, with the single depth read
// port scanning the candidate window once per chosen id.
// Reset clears the configuration to server count 1, local id 0 and random
// policy; table contents are undefined until written.
// A stalled receiver holds the output register; the block waits and loses
// nothing.
`default_nettype none

module storage_server_selector_unit #(
    parameter int MAX_SERVERS = ssel_pkg::MAX_SERVERS_DEF,
    parameter int MAX_SELECT  = ssel_pkg::MAX_SELECT_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [ssel_pkg::CIDX_W-1:0] i_cfg_idx,
    input  wire [ssel_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  ssel_pkg::t_in_word         i_in_word,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output ssel_pkg::t_out_word        o_out_word
);

    ssel_pkg::t_cmd    w_cmd;
    ssel_pkg::t_status w_status;

    // Sequencer.
    ssel_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Tables, divider, minimum search and output register.
    ssel_dp #(
        .MAX_SERVERS (MAX_SERVERS),
        .MAX_SELECT  (MAX_SELECT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

`default_nettype wire
